@@ rtl/core/cpdf_pkg.sv @@
// ----------------------------------------------------------------------------
// cpdf_pkg: shared types and constants
// Sizes, controller states and the control/status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package cpdf_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLUMNS = 16;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int CELLS       = MAX_ROWS * MAX_COLUMNS;
  localparam int HASH_W      = 64;
  localparam int ROWCNT_W    = 11;
  localparam int COLCNT_W    = 5;

  localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RD_I,
    S_CAP_I,
    S_RD_J,
    S_CMP_J,
    S_PAIR_END,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic srch_init;
    logic sel_j;
    logic cap_i;
    logic cmp_j;
    logic next_i;
    logic next_pair;
  } cmd_t;

  typedef struct packed {
    logic last_cell;
    logic size_ok;
    logic stop_j;
    logic i_last;
    logic pair_last;
    logic best_valid;
  } status_t;

endpackage

@@ rtl/core/cpdf_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpdf_ctrl: search sequencer
// Walks column pairs, anchor rows and candidate rows, and issues datapath
// commands for each step.
// ----------------------------------------------------------------------------
module cpdf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  cpdf_pkg::status_t sts,
  output cpdf_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             report
);
  import cpdf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && sts.last_cell) state_nxt = S_START;
      end
      S_START: begin
        state_nxt = sts.size_ok ? S_RD_I : S_REPORT;
      end
      S_RD_I:  state_nxt = S_CAP_I;
      S_CAP_I: state_nxt = S_RD_J;
      S_RD_J:  state_nxt = S_CMP_J;
      S_CMP_J: begin
        if (!sts.stop_j) state_nxt = S_RD_J;
        else if (sts.i_last) state_nxt = S_PAIR_END;
        else state_nxt = S_RD_I;
      end
      S_PAIR_END: begin
        if (sts.best_valid || sts.pair_last) state_nxt = S_REPORT;
        else state_nxt = S_RD_I;
      end
      S_REPORT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    busy   = (state_r != S_IDLE);
    report = (state_r == S_REPORT);
    case (state_r)
      S_START: cmd.srch_init = 1'b1;
      S_CAP_I: cmd.cap_i = 1'b1;
      S_RD_J:  cmd.sel_j = 1'b1;
      S_CMP_J: begin
        cmd.cmp_j  = 1'b1;
        cmd.next_i = sts.stop_j && !sts.i_last;
      end
      S_PAIR_END: cmd.next_pair = !sts.best_valid && !sts.pair_last;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/cpdf_dp.sv @@
// ----------------------------------------------------------------------------
// cpdf_dp: hash loader, cell store and pair comparator
// Builds cell hashes, keeps them in a two-read-port memory and compares row
// keys for the search.
// ----------------------------------------------------------------------------
module cpdf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          in_mode,
  input  logic [7:0]                    in_char_code,
  input  logic [cpdf_pkg::ROWCNT_W-1:0] row_count,
  input  logic [cpdf_pkg::COLCNT_W-1:0] column_count,
  input  cpdf_pkg::cmd_t                cmd,
  output cpdf_pkg::status_t             sts,
  output logic                          found,
  output logic [cpdf_pkg::ROWCNT_W-1:0] first_row,
  output logic [cpdf_pkg::ROWCNT_W-1:0] second_row,
  output logic [cpdf_pkg::COLCNT_W-1:0] first_column,
  output logic [cpdf_pkg::COLCNT_W-1:0] second_column
);
  import cpdf_pkg::*;

  logic [HASH_W-1:0] mem [CELLS];
  logic [HASH_W-1:0] rd_a_r, rd_b_r;

  logic [HASH_W-1:0] hash_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [COL_W-1:0]  cur_col_r;

  logic [ROW_W-1:0]  n_m1;
  logic [COL_W-1:0]  m_m1;

  logic [COL_W-1:0]  l_r, r_r;
  logic [ROW_W-1:0]  i_r, j_r;
  logic [HASH_W-1:0] key_l_r, key_r_r;
  logic              best_valid_r;
  logic [HASH_W-1:0] best_l_r, best_r_r;
  logic [ROW_W-1:0]  best_p_r, best_q_r;

  logic [ROW_W-1:0]  rd_row;
  logic              wen, match, better;
  logic [COLCNT_W-1:0] col_inc;
  logic [ROWCNT_W-1:0] row_inc;

  // Rows and columns in use, with out-of-range counts pinned to the limits.
  always_comb begin
    if (row_count == '0) n_m1 = '0;
    else if (row_count > ROWCNT_W'(MAX_ROWS)) n_m1 = ROW_W'(MAX_ROWS - 1);
    else n_m1 = ROW_W'(row_count - 1'b1);
    if (column_count == '0) m_m1 = '0;
    else if (column_count > COLCNT_W'(MAX_COLUMNS)) m_m1 = COL_W'(MAX_COLUMNS - 1);
    else m_m1 = COL_W'(column_count - 1'b1);
  end

  assign col_inc = {1'b0, cur_col_r} + 1'b1;
  assign row_inc = {1'b0, cur_row_r} + 1'b1;
  assign wen     = accept && in_mode;

  assign sts.last_cell = in_mode && (col_inc > {1'b0, m_m1}) && (row_inc > {1'b0, n_m1});
  assign sts.size_ok   = (n_m1 != '0) && (m_m1 != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r    <= '0;
      cur_row_r <= '0;
      cur_col_r <= '0;
    end else if (accept) begin
      if (!in_mode) begin
        hash_r <= (hash_r << 7) + (hash_r << 3) + hash_r + HASH_W'(in_char_code);
      end else begin
        hash_r <= '0;
        if (col_inc > {1'b0, m_m1}) begin
          cur_col_r <= '0;
          cur_row_r <= (row_inc > {1'b0, n_m1}) ? '0 : ROW_W'(row_inc);
        end else begin
          cur_col_r <= COL_W'(col_inc);
        end
      end
    end
  end

  assign rd_row = cmd.sel_j ? j_r : i_r;

  always_ff @(posedge clk) begin
    if (wen) mem[{cur_row_r, cur_col_r}] <= hash_r;
    rd_a_r <= mem[{rd_row, l_r}];
    rd_b_r <= mem[{rd_row, r_r}];
  end

  assign match  = (rd_a_r == key_l_r) && (rd_b_r == key_r_r);
  assign better = !best_valid_r || (key_l_r < best_l_r) ||
                  ((key_l_r == best_l_r) && (key_r_r < best_r_r));

  assign sts.stop_j     = match || (j_r == n_m1);
  assign sts.i_last     = ({1'b0, i_r} + 1'b1) == {1'b0, n_m1};
  assign sts.pair_last  = (r_r == m_m1) && (({1'b0, l_r} + 1'b1) == {1'b0, m_m1});
  assign sts.best_valid = best_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      l_r <= '0;
      r_r <= '0;
      i_r <= '0;
      j_r <= '0;
    end else begin
      if (cmd.srch_init) begin
        best_valid_r <= 1'b0;
        l_r <= '0;
        r_r <= COL_W'(1);
        i_r <= '0;
      end
      if (cmd.next_pair) begin
        i_r <= '0;
        if (r_r != m_m1) begin
          r_r <= r_r + 1'b1;
        end else begin
          l_r <= l_r + 1'b1;
          r_r <= l_r + COL_W'(2);
        end
      end
      if (cmd.cap_i) j_r <= i_r + 1'b1;
      if (cmd.cmp_j && !sts.stop_j) j_r <= j_r + 1'b1;
      if (cmd.next_i) i_r <= i_r + 1'b1;
      if (cmd.cmp_j && match && better) best_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_i) begin
      key_l_r <= rd_a_r;
      key_r_r <= rd_b_r;
    end
    if (cmd.cmp_j && match && better) begin
      best_l_r <= key_l_r;
      best_r_r <= key_r_r;
      best_p_r <= i_r;
      best_q_r <= j_r;
    end
  end

  assign found         = best_valid_r;
  assign first_row     = best_valid_r ? ({1'b0, best_p_r} + 1'b1) : '0;
  assign second_row    = best_valid_r ? ({1'b0, best_q_r} + 1'b1) : '0;
  assign first_column  = best_valid_r ? ({1'b0, l_r} + 1'b1) : '0;
  assign second_column = best_valid_r ? ({1'b0, r_r} + 1'b1) : '0;

endmodule

@@ rtl/core/column_pair_duplicate_finder_top.sv @@
// ----------------------------------------------------------------------------
// column_pair_duplicate_finder_top: duplicate row pair search over a table
// Loads text cells as hashes and searches column pairs for repeated rows.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_mode/in_char_code and are taken at a clock edge where
// start is high and busy is low. A character item folds into the running
// cell hash (hash * 137 + char); an end-of-cell item stores the hash and
// moves to the next cell in row-major order. Loading takes one item per cycle.
// The end-of-cell item of the last cell starts the search and raises busy.
// The search tries column pairs (l < r) in order; for each pair it compares
// every anchor row against the later rows, up to the first match, reading
// both keys of a row from the single two-port hash memory, and it stops after
// the first pair with a match. A table with one row or one column gives a
// not-found result without a search. It ends with one result item shown for
// one cycle with out_valid; the receiver cannot stall and must take it then.
// busy falls on the next cycle. Registers row_count (address 0) and
// column_count (address 4) are written over APB; the user must write them
// only while the block is idle, which the block does not enforce. Reset clears
// the load position, the running hash and the controller, not the hash memory.
// ----------------------------------------------------------------------------
module column_pair_duplicate_finder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [7:0]                    in_char_code,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [cpdf_pkg::ROWCNT_W-1:0] out_first_row,
  output logic [cpdf_pkg::ROWCNT_W-1:0] out_second_row,
  output logic [cpdf_pkg::COLCNT_W-1:0] out_first_column,
  output logic [cpdf_pkg::COLCNT_W-1:0] out_second_column,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import cpdf_pkg::*;

  logic [ROWCNT_W-1:0] row_count_r;
  logic [COLCNT_W-1:0] column_count_r;
  logic [1:0]          reg_idx;
  logic                accept;
  cmd_t                cmd;
  status_t             sts;

  // Registers sit on 4-byte steps, so address bit 2 picks the register.
  assign reg_idx = {1'b0, paddr[2]};
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROWCNT_W'(1);
      column_count_r <= COLCNT_W'(1);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_ROW_COUNT:    row_count_r    <= pwdata[ROWCNT_W-1:0];
        REG_COLUMN_COUNT: column_count_r <= pwdata[COLCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_COUNT:    prdata = {{(32-ROWCNT_W){1'b0}}, row_count_r};
      REG_COLUMN_COUNT: prdata = {{(32-COLCNT_W){1'b0}}, column_count_r};
      default:          prdata = '0;
    endcase
  end

  // An item is taken only while no search is running.
  assign accept = start && !busy;

  cpdf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .report (out_valid)
  );

  cpdf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_mode       (in_mode),
    .in_char_code  (in_char_code),
    .row_count     (row_count_r),
    .column_count  (column_count_r),
    .cmd           (cmd),
    .sts           (sts),
    .found         (out_found),
    .first_row     (out_first_row),
    .second_row    (out_second_row),
    .first_column  (out_first_column),
    .second_column (out_second_column)
  );

  // A result only appears at the end of a search.
  a_result_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a search");

  // One search gives exactly one result.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result repeated");

  // A found pair is ordered in both rows and columns.
  a_pair_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> (out_first_row < out_second_row) &&
    (out_first_column < out_second_column)) else $error("pair out of order");

  // A not-found result carries all-zero fields.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_first_row == '0) && (out_second_row == '0) &&
    (out_first_column == '0) && (out_second_column == '0))
    else $error("not-found result has nonzero fields");

endmodule

@@ dv/column_pair_duplicate_finder_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_pair_duplicate_finder_top_tb: self-checking bench for the finder
// Streams tables of text cells into the block, predicts the duplicate row
// pair report of every table and compares each reported item field by field.
// ----------------------------------------------------------------------------
module column_pair_duplicate_finder_top_tb;
  import cpdf_pkg::*;

  // One search report, laid out like the result ports.
  typedef struct packed {
    logic                found;
    logic [ROWCNT_W-1:0] first_row;
    logic [ROWCNT_W-1:0] second_row;
    logic [COLCNT_W-1:0] first_column;
    logic [COLCNT_W-1:0] second_column;
  } pair_report_t;

  // The predictor keeps its own copy of the table, the load position and the
  // two count registers, and queues one report per completed table.
  class dup_pair_scoreboard;
    logic [HASH_W-1:0]   cell_hash [CELLS];
    logic [HASH_W-1:0]   cell_accum;
    int unsigned         load_row, load_col;
    logic [ROWCNT_W-1:0] row_reg;
    logic [COLCNT_W-1:0] col_reg;
    pair_report_t        pending_reports[$];
    int unsigned         mismatches, reports_checked, tables_found;

    function new();
      cell_accum = '0;
      load_row = 0;
      load_col = 0;
      row_reg = ROWCNT_W'(1);
      col_reg = COLCNT_W'(1);
      mismatches = 0;
      reports_checked = 0;
      tables_found = 0;
    endfunction

    // Out-of-range counts are clamped into 1..MAX.
    function int unsigned rows_used();
      if (row_reg == 0) return 1;
      if (row_reg > MAX_ROWS) return MAX_ROWS;
      return row_reg;
    endfunction

    function int unsigned cols_used();
      if (col_reg == 0) return 1;
      if (col_reg > MAX_COLUMNS) return MAX_COLUMNS;
      return col_reg;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      if (idx == REG_ROW_COUNT) row_reg = value[ROWCNT_W-1:0];
      else if (idx == REG_COLUMN_COUNT) col_reg = value[COLCNT_W-1:0];
    endfunction

    // Within the first column pair that has any repeated (l, r) key, the
    // smallest such key wins, reported by its two lowest rows.
    function pair_report_t find_pair();
      pair_report_t      rep;
      int unsigned       n, m, bi, bj;
      logic [2*HASH_W-1:0] best_key, key;
      bit                hit;
      n = rows_used();
      m = cols_used();
      rep = '0;
      for (int unsigned l = 0; l < m; l++) begin
        for (int unsigned r = l + 1; r < m; r++) begin
          hit = 0;
          for (int unsigned i = 0; i < n; i++) begin
            for (int unsigned j = i + 1; j < n; j++) begin
              if (cell_hash[i*MAX_COLUMNS+l] == cell_hash[j*MAX_COLUMNS+l] &&
                  cell_hash[i*MAX_COLUMNS+r] == cell_hash[j*MAX_COLUMNS+r]) begin
                key = {cell_hash[i*MAX_COLUMNS+l], cell_hash[i*MAX_COLUMNS+r]};
                if (!hit || key < best_key) begin
                  hit = 1;
                  best_key = key;
                  bi = i;
                  bj = j;
                end
                break;
              end
            end
          end
          if (hit) begin
            rep.found = 1'b1;
            rep.first_row = ROWCNT_W'(bi + 1);
            rep.second_row = ROWCNT_W'(bj + 1);
            rep.first_column = COLCNT_W'(l + 1);
            rep.second_column = COLCNT_W'(r + 1);
            return rep;
          end
        end
      end
      return rep;
    endfunction

    function void note_item(logic mode, logic [7:0] code);
      pair_report_t rep;
      if (mode == 1'b0) begin
        cell_accum = cell_accum * 64'd137 + {56'd0, code};
        return;
      end
      if (load_row < MAX_ROWS && load_col < MAX_COLUMNS)
        cell_hash[load_row*MAX_COLUMNS+load_col] = cell_accum;
      cell_accum = '0;
      load_col++;
      if (load_col >= cols_used()) begin
        load_col = 0;
        load_row++;
        if (load_row >= rows_used()) begin
          load_row = 0;
          rep = find_pair();
          if (rep.found) tables_found++;
          pending_reports.push_back(rep);
        end
      end
    endfunction

    function void check_report(pair_report_t got);
      pair_report_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected report %h", got);
        return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      if (got.found !== want.found || got.first_row !== want.first_row ||
          got.second_row !== want.second_row ||
          got.first_column !== want.first_column ||
          got.second_column !== want.second_column) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: report mismatch: expected f=%0d rows %0d,%0d ",
                    "cols %0d,%0d; got f=%0d rows %0d,%0d cols %0d,%0d"},
                   want.found, want.first_row, want.second_row, want.first_column,
                   want.second_column, got.found, got.first_row, got.second_row,
                   got.first_column, got.second_column);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_mode;
  logic [7:0]          in_char_code;
  logic                out_valid;
  logic                out_found;
  logic [ROWCNT_W-1:0] out_first_row;
  logic [ROWCNT_W-1:0] out_second_row;
  logic [COLCNT_W-1:0] out_first_column;
  logic [COLCNT_W-1:0] out_second_column;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  dup_pair_scoreboard sb;
  int unsigned        gap_pct;
  int unsigned        items_sent;
  int unsigned        tables_sent;

  column_pair_duplicate_finder_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_char_code(in_char_code),
    .out_valid(out_valid), .out_found(out_found),
    .out_first_row(out_first_row), .out_second_row(out_second_row),
    .out_first_column(out_first_column), .out_second_column(out_second_column),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reports cannot be held off, so every strobed cycle is checked as is.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_report({out_found, out_first_row, out_second_row,
                       out_first_column, out_second_column});
  end

  // Offers one item, possibly after a random gap, and returns at the edge
  // that takes it. The next call may keep start high without a dip.
  task automatic send_item(logic mode, logic [7:0] code);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_char_code <= code;
    do @(posedge clk); while (busy);
    sb.note_item(mode, code);
    items_sent++;
  endtask

  // Waits until every predicted report has come and the block is quiet.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_reports.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 1'b0} << 1;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // A cell's text: a negative code gives random bytes of any value, a
  // non-negative one a short fixed text so that repeated cells are common.
  task automatic send_cell(int code);
    int unsigned len;
    if (code < 0) begin
      len = $urandom_range(0, 4);
      for (int unsigned k = 0; k < len; k++) send_item(1'b0, 8'($urandom));
    end else begin
      for (int k = 0; k < code % 3; k++) send_item(1'b0, 8'(code * 37 + k));
    end
    send_item(1'b1, 8'($urandom));
  endtask

  // Loads one whole table. A small pool makes duplicate rows likely;
  // pool 0 gives all-random text.
  task automatic send_table(int unsigned n, int unsigned m, int unsigned pool);
    for (int unsigned i = 0; i < n * m; i++)
      send_cell(pool == 0 ? -1 : int'($urandom_range(0, pool - 1)));
    tables_sent++;
  endtask

  initial begin
    int unsigned n, m;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = 1'b0;
    in_char_code = 8'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gap_pct = 21;
    items_sent = 0;
    tables_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset counts give a one-cell table, and an empty cell hashes
    // to zero; a single column can never report a pair.
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h00);
    tables_sent += 2;
    // Two identical rows of two columns give a hit on rows 1,2, columns 1,2.
    write_reg(REG_ROW_COUNT, 2);
    write_reg(REG_COLUMN_COUNT, 2);
    send_cell(4); send_cell(5); send_cell(4); send_cell(5);
    // Two distinct rows give not found.
    send_cell(1); send_cell(2); send_cell(7); send_cell(2);
    tables_sent += 2;
    // Widest table, and an out-of-range column count acting as the maximum.
    write_reg(REG_COLUMN_COUNT, MAX_COLUMNS);
    send_table(2, MAX_COLUMNS, 2);
    write_reg(REG_COLUMN_COUNT, 31);
    send_table(2, MAX_COLUMNS, 2);
    // Zero row count acts as one row.
    write_reg(REG_ROW_COUNT, 0);
    send_table(1, MAX_COLUMNS, 0);
    // Zero column count acts as one column.
    write_reg(REG_COLUMN_COUNT, 0);
    write_reg(REG_ROW_COUNT, 5);
    send_table(5, 1, 2);
    // Column count shrunk mid-row: the next cell still lands at the old
    // position and then wraps to the next row.
    write_reg(REG_ROW_COUNT, 3);
    write_reg(REG_COLUMN_COUNT, 4);
    for (int i = 0; i < 7; i++) send_cell(i % 2);
    write_reg(REG_COLUMN_COUNT, 2);
    send_cell(1); send_cell(0); send_cell(1);
    tables_sent++;

    // Random tables, mostly small, in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = phase == 0 ? 21 : (phase == 1 ? 61 : 0);
      repeat (5) begin
        n = $urandom_range(1, 12);
        m = $urandom_range(1, 6);
        write_reg(REG_ROW_COUNT, n);
        write_reg(REG_COLUMN_COUNT, m);
        repeat ($urandom_range(1, 2)) send_table(n, m, $urandom_range(0, 3));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d items over %0d tables; %0d reports checked, %0d with a pair.",
             items_sent, tables_sent, sb.reports_checked, sb.tables_found);
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d reports missing", sb.mismatches,
               sb.pending_reports.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timeout while waiting for the block");
    $display("TEST FAILED");
    $finish;
  end

endmodule
